/* design/oga_pkg.sv */
// oga_pkg: shared types and constants for the overlap group assigner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oga_pkg;

  localparam int IN_COORD_W = 16;
  localparam int GIDX_W     = 6;
  localparam int AREA_W     = 32;

  localparam logic [AREA_W-1:0] AREA_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } oga_state_t;

endpackage

`default_nettype wire

/* design/overlap_group_assigner.sv */
// After the accepting edge the block scans the table, drains the area pipeline and decides,
// then registers out_valid; one stored group is read per cycle from the memory port.
// No rectangle is taken while one is in flight; start is taken again in the out_valid cycle.
// Results are a one-cycle strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the group table; memory contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module overlap_group_assigner #(
  parameter int MAX_GROUPS = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_clear_groups,
  input  wire logic [oga_pkg::IN_COORD_W-1:0]       in_rect_left,
  input  wire logic [oga_pkg::IN_COORD_W-1:0]       in_rect_top,
  input  wire logic [oga_pkg::IN_COORD_W-1:0]       in_rect_width,
  input  wire logic [oga_pkg::IN_COORD_W-1:0]       in_rect_height,
  output logic                                      out_valid,
  output logic [oga_pkg::GIDX_W-1:0]                out_group_index,
  output logic                                      out_new_group,
  output logic                                      out_table_full,
  output logic [oga_pkg::AREA_W-1:0]                out_overlap_area
);

  import oga_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CNT_W = $clog2(MAX_GROUPS + 1);

  logic [4*CW-1:0]  in_rect, rect_r, rd_data;
  logic             rd_en, wr_en, rd_vld, pipe_busy, area_vld;
  logic [IDX_W-1:0] rd_addr, wr_addr, rd_idx, area_idx;
  logic [2*CW-1:0]  area;

  assign in_rect = {CW'(in_rect_left), CW'(in_rect_top),
                    CW'(in_rect_width), CW'(in_rect_height)};

  oga_store #(
    .DEPTH (MAX_GROUPS),
    .WIDTH (4*CW),
    .IDX_W (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (rect_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_vld_r  (rd_vld),
    .rd_idx_r  (rd_idx),
    .rd_data_r (rd_data)
  );

  oga_area #(
    .CW    (CW),
    .IDX_W (IDX_W)
  ) u_area (
    .clk        (clk),
    .rst_n      (rst_n),
    .new_rect   (rect_r),
    .grp_rect   (rd_data),
    .in_vld     (rd_vld),
    .in_idx     (rd_idx),
    .pipe_busy  (pipe_busy),
    .area_vld_r (area_vld),
    .area_idx_r (area_idx),
    .area_r     (area)
  );

  oga_ctrl #(
    .MAX_GROUPS (MAX_GROUPS),
    .CW         (CW),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_clear           (in_clear_groups),
    .in_rect            (in_rect),
    .busy               (busy),
    .rect_r             (rect_r),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .pipe_busy          (pipe_busy),
    .area_vld           (area_vld),
    .area_idx           (area_idx),
    .area               (area),
    .out_valid_r        (out_valid),
    .out_group_index_r  (out_group_index),
    .out_new_group_r    (out_new_group),
    .out_table_full_r   (out_table_full),
    .out_overlap_area_r (out_overlap_area)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |->
      (!out_new_group && out_group_index == '0 && out_overlap_area == '0))
    else $error("dropped rectangle with non-zero result fields");

  a_new_no_area: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_new_group) |-> (out_overlap_area == '0))
    else $error("new group reported an overlap");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && !pipe_busy)
    else $error("table written while a scan is in flight");

endmodule

`default_nettype wire

/* design/oga_store.sv */
// oga_store: group representative memory, one write and one registered read port.
// Read beats carry a valid flag and their index alongside the data.
`timescale 1ns / 1ps
`default_nettype none

module oga_store #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 64,
  parameter int IDX_W  = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic                  rd_vld_r,
  output logic [IDX_W-1:0]      rd_idx_r,
  output logic [WIDTH-1:0]      rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    rd_idx_r  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

endmodule

`default_nettype wire

/* design/oga_area.sv */
// oga_area: shared overlap unit, two stages (axis overlaps, then product).
// Fed one stored rectangle per beat from oga_store; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module oga_area #(
  parameter int CW    = 16,
  parameter int IDX_W = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [4*CW-1:0]   new_rect,
  input  wire logic [4*CW-1:0]   grp_rect,
  input  wire logic              in_vld,
  input  wire logic [IDX_W-1:0]  in_idx,
  output logic                   pipe_busy,
  output logic                   area_vld_r,
  output logic [IDX_W-1:0]       area_idx_r,
  output logic [2*CW-1:0]        area_r
);

  logic [CW-1:0] ow_nxt, oh_nxt, ow_r, oh_r;
  logic          s1_vld_r;
  logic [IDX_W-1:0] s1_idx_r;

  function automatic logic [CW-1:0] axis_ov(input logic [CW-1:0] a0, input logic [CW-1:0] al,
                                            input logic [CW-1:0] b0, input logic [CW-1:0] bl);
    logic [CW:0] a1, b1, lo, hi, d;
    a1 = {1'b0, a0} + {1'b0, al};
    b1 = {1'b0, b0} + {1'b0, bl};
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi = (a1 < b1) ? a1 : b1;
    d  = hi - lo;
    return (hi > lo) ? d[CW-1:0] : '0;
  endfunction

  // packing: {left, top, width, height}
  always_comb begin
    ow_nxt = axis_ov(grp_rect[4*CW-1:3*CW], grp_rect[2*CW-1:CW],
                     new_rect[4*CW-1:3*CW], new_rect[2*CW-1:CW]);
    oh_nxt = axis_ov(grp_rect[3*CW-1:2*CW], grp_rect[CW-1:0],
                     new_rect[3*CW-1:2*CW], new_rect[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    ow_r       <= ow_nxt;
    oh_r       <= oh_nxt;
    s1_idx_r   <= in_idx;
    area_r     <= (2*CW)'(ow_r) * (2*CW)'(oh_r);
    area_idx_r <= s1_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      area_vld_r <= 1'b0;
    end else begin
      s1_vld_r   <= in_vld;
      area_vld_r <= s1_vld_r;
    end
  end

  assign pipe_busy = in_vld | s1_vld_r | area_vld_r;

endmodule

`default_nettype wire

/* design/oga_ctrl.sv */
// oga_ctrl: sequencer, group count, best-match tracking and result register.
// Uses oga_pkg; drives oga_store and consumes beats from oga_area.
`timescale 1ns / 1ps
`default_nettype none

module oga_ctrl #(
  parameter int MAX_GROUPS = 64,
  parameter int CW         = 16,
  parameter int IDX_W      = 6,
  parameter int CNT_W      = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic                       in_clear,
  input  wire logic [4*CW-1:0]            in_rect,
  output logic                            busy,
  output logic [4*CW-1:0]                 rect_r,
  output logic                            rd_en,
  output logic [IDX_W-1:0]                rd_addr,
  output logic                            wr_en,
  output logic [IDX_W-1:0]                wr_addr,
  input  wire logic                       pipe_busy,
  input  wire logic                       area_vld,
  input  wire logic [IDX_W-1:0]           area_idx,
  input  wire logic [2*CW-1:0]            area,
  output logic                            out_valid_r,
  output logic [oga_pkg::GIDX_W-1:0]      out_group_index_r,
  output logic                            out_new_group_r,
  output logic                            out_table_full_r,
  output logic [oga_pkg::AREA_W-1:0]      out_overlap_area_r
);

  import oga_pkg::*;

  oga_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [2*CW-1:0]  best_area_r, best_area_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             accept, found, has_room, last_issue, sat;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign found      = (best_area_r != '0);
  assign has_room   = (count_r < CNT_W'(MAX_GROUPS));
  assign last_issue = ((CNT_W'(scan_r) + CNT_W'(1)) == count_r);
  assign sat        = (64'(best_area_r) > 64'(AREA_MAX));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    best_area_nxt = best_area_r;
    best_idx_nxt  = best_idx_r;
    rd_en         = 1'b0;
    rd_addr       = scan_r;
    wr_en         = 1'b0;
    wr_addr       = found ? best_idx_r : count_r[IDX_W-1:0];

    if (area_vld && (area > best_area_r)) begin
      best_area_nxt = area;
      best_idx_nxt  = area_idx;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_clear) begin
            count_nxt = '0;
          end
          scan_nxt      = '0;
          best_area_nxt = '0;
          best_idx_nxt  = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (count_r == '0) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_en = 1'b1;
          if (last_issue) begin
            state_nxt = ST_DRAIN;
          end else begin
            scan_nxt = scan_r + IDX_W'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        wr_en = found || has_room;
        if (!found && has_room) begin
          count_nxt = count_r + CNT_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == ST_DECIDE);
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    best_area_r <= best_area_nxt;
    best_idx_r  <= best_idx_nxt;
    if (accept) begin
      rect_r <= in_rect;
    end
    if (state_r == ST_DECIDE) begin
      out_new_group_r  <= !found && has_room;
      out_table_full_r <= !found && !has_room;
      if (found) begin
        out_group_index_r  <= GIDX_W'(best_idx_r);
        out_overlap_area_r <= sat ? AREA_MAX : AREA_W'(best_area_r);
      end else begin
        out_group_index_r  <= has_room ? GIDX_W'(count_r) : '0;
        out_overlap_area_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/overlap_group_assigner_test.sv */
// overlap_group_assigner_test: self-checking bench for overlap_group_assigner.
// It predicts each result from a local copy of the group table and checks every beat.
// Depends on oga_pkg and overlap_group_assigner.
`timescale 1ns / 1ps

module overlap_group_assigner_test;
  import oga_pkg::*;

  localparam int MAX_GROUPS       = 64;
  localparam int DRAIN_CYCLES     = MAX_GROUPS + 8;
  localparam int MISMATCH_REPORTS = 10;

  typedef struct packed {
    logic                  clear;
    logic [IN_COORD_W-1:0] left;
    logic [IN_COORD_W-1:0] top;
    logic [IN_COORD_W-1:0] width;
    logic [IN_COORD_W-1:0] height;
  } rect_t;

  typedef struct packed {
    logic [GIDX_W-1:0] group_index;
    logic              new_group;
    logic              table_full;
    logic [AREA_W-1:0] area;
  } verdict_t;

  typedef enum int {
    MODE_TRACK,
    MODE_SPREAD,
    MODE_MIXED
  } traffic_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_clear_groups;
  logic [IN_COORD_W-1:0] in_rect_left;
  logic [IN_COORD_W-1:0] in_rect_top;
  logic [IN_COORD_W-1:0] in_rect_width;
  logic [IN_COORD_W-1:0] in_rect_height;
  logic                  out_valid;
  logic [GIDX_W-1:0]     out_group_index;
  logic                  out_new_group;
  logic                  out_table_full;
  logic [AREA_W-1:0]     out_overlap_area;

  verdict_t    awaited_results[$];
  rect_t       rep_rect[MAX_GROUPS];
  int unsigned rep_count;
  int unsigned fail_count;
  int unsigned idle_pct;

  overlap_group_assigner uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_clear_groups  (in_clear_groups),
    .in_rect_left     (in_rect_left),
    .in_rect_top      (in_rect_top),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .out_valid        (out_valid),
    .out_group_index  (out_group_index),
    .out_new_group    (out_new_group),
    .out_table_full   (out_table_full),
    .out_overlap_area (out_overlap_area)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [IN_COORD_W:0] axis_span(logic [IN_COORD_W-1:0] a0,
                                                    logic [IN_COORD_W-1:0] alen,
                                                    logic [IN_COORD_W-1:0] b0,
                                                    logic [IN_COORD_W-1:0] blen);
    logic [IN_COORD_W:0] a1, b1, lo, hi;
    a1 = a0 + alen;
    b1 = b0 + blen;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  function automatic verdict_t assign_rect(rect_t r);
    verdict_t    v;
    logic [63:0] best_area;
    logic [63:0] area;
    int unsigned best_idx;
    v = '0;
    best_area = '0;
    best_idx = 0;
    if (r.clear) rep_count = 0;
    for (int i = 0; i < rep_count; i++) begin
      area = 64'(axis_span(rep_rect[i].left, rep_rect[i].width, r.left, r.width)) *
             64'(axis_span(rep_rect[i].top, rep_rect[i].height, r.top, r.height));
      if (area > best_area) begin
        best_area = area;
        best_idx = i;
      end
    end
    if (best_area != 0) begin
      rep_rect[best_idx] = r;
      v.group_index = best_idx[GIDX_W-1:0];
      v.area = (best_area > 64'(AREA_MAX)) ? AREA_MAX : best_area[AREA_W-1:0];
    end else if (rep_count < MAX_GROUPS) begin
      rep_rect[rep_count] = r;
      v.group_index = rep_count[GIDX_W-1:0];
      v.new_group = 1'b1;
      rep_count++;
    end else begin
      v.table_full = 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk) begin : result_check
    verdict_t got;
    verdict_t want;
    if (rst_n && out_valid) begin
      got = {out_group_index, out_new_group, out_table_full, out_overlap_area};
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MISMATCH_REPORTS)
          $display("unexpected result beat: group %0d new %0b full %0b area %h",
                   got.group_index, got.new_group, got.table_full, got.area);
      end else begin
        want = awaited_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MISMATCH_REPORTS)
            $display("mismatch: expected group %0d new %0b full %0b area %h,",
                     want.group_index, want.new_group, want.table_full, want.area,
                     " got group %0d new %0b full %0b area %h",
                     got.group_index, got.new_group, got.table_full, got.area);
        end
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with start possibly still high.
  task automatic send_rect(rect_t r);
    in_clear_groups <= r.clear;
    in_rect_left    <= r.left;
    in_rect_top     <= r.top;
    in_rect_width   <= r.width;
    in_rect_height  <= r.height;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    awaited_results.insert(awaited_results.size(), assign_rect(r));
    @(negedge clk);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(90, 4) : $urandom_range(3, 1))
        @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    int unsigned n = 0;
    start <= 1'b0;
    while (awaited_results.size() != 0 && n < 4 * DRAIN_CYCLES) begin
      @(negedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic rect_t rect_of(logic c, int unsigned l, int unsigned t,
                                    int unsigned w, int unsigned h);
    return {c, IN_COORD_W'(l), IN_COORD_W'(t), IN_COORD_W'(w), IN_COORD_W'(h)};
  endfunction

  function automatic rect_t random_rect(traffic_mode_t mode);
    rect_t       r;
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    r.clear = (mode != MODE_SPREAD) && ($urandom_range(99) < 4);
    if (mode == MODE_SPREAD) begin
      // 16x16 slots, 4096 px apart; rectangles never reach a neighbouring slot
      k = $urandom_range(255);
      r.left   = IN_COORD_W'((k % 16) * 4096 + $urandom_range(1000));
      r.top    = IN_COORD_W'((k / 16) * 4096 + $urandom_range(1000));
      r.width  = IN_COORD_W'($urandom_range(3000, 1));
      r.height = IN_COORD_W'($urandom_range(3000, 1));
    end else if ((mode == MODE_MIXED && pick < 40) || pick < 10) begin
      r.left   = IN_COORD_W'($urandom_range(65535));
      r.top    = IN_COORD_W'($urandom_range(65535));
      r.width  = IN_COORD_W'($urandom_range(65535));
      r.height = IN_COORD_W'($urandom_range(65535));
    end else begin
      k = $urandom_range(7);
      r.left   = IN_COORD_W'(k * 6000 + $urandom_range(400));
      r.top    = IN_COORD_W'($urandom_range(1) * 6000 + $urandom_range(400));
      r.width  = (pick < 15) ? '0 : IN_COORD_W'($urandom_range(800, 1));
      r.height = (pick >= 95) ? '0 : IN_COORD_W'($urandom_range(800, 1));
    end
    return r;
  endfunction

  task automatic test_first_group();
    send_rect(rect_of(1'b0, 10, 10, 20, 20));
    send_rect(rect_of(1'b0, 12, 12, 5, 5));
  endtask

  // touching edges and degenerate sizes never join
  task automatic test_overlap_rules();
    send_rect(rect_of(1'b0, 17, 10, 10, 10));
    send_rect(rect_of(1'b0, 0, 17, 40, 3));
    send_rect(rect_of(1'b0, 13, 13, 0, 10));
    send_rect(rect_of(1'b0, 13, 13, 10, 0));
    send_rect(rect_of(1'b0, 14, 14, 2, 2));
  endtask

  task automatic test_tie_break();
    send_rect(rect_of(1'b1, 0, 0, 10, 10));
    send_rect(rect_of(1'b0, 20, 0, 10, 10));
    send_rect(rect_of(1'b0, 5, 0, 20, 10));
    send_rect(rect_of(1'b0, 7, 0, 20, 10));
  endtask

  task automatic test_coordinate_extremes();
    send_rect(rect_of(1'b1, 65535, 65535, 65535, 65535));
    send_rect(rect_of(1'b0, 0, 0, 65535, 65535));
    send_rect(rect_of(1'b0, 65534, 65534, 2, 2));
    send_rect(rect_of(1'b0, 0, 0, 65535, 65535));
    send_rect(rect_of(1'b0, 65535, 0, 0, 65535));
    send_rect(rect_of(1'b1, 0, 0, 0, 0));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < MAX_GROUPS; i++)
      send_rect(rect_of(i == 0, (i % 8) * 1000, (i / 8) * 1000, 500, 500));
    send_rect(rect_of(1'b0, 9000, 9000, 10, 10));
    send_rect(rect_of(1'b0, 5200, 200, 100, 100));
    send_rect(rect_of(1'b0, 0, 60000, 65535, 100));
    wait_drained();
    send_rect(rect_of(1'b1, 9000, 9000, 10, 10));
  endtask

  task automatic test_random_traffic(int unsigned n_items, int unsigned pct);
    traffic_mode_t mode;
    int unsigned   sent;
    idle_pct = pct;
    sent = 0;
    while (sent < n_items) begin
      mode = traffic_mode_t'($urandom_range(2));
      repeat ((mode == MODE_SPREAD) ? 90 : 30) begin
        if (sent < n_items) begin
          send_rect(random_rect(mode));
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_clear_groups = 1'b0;
    in_rect_left    = '0;
    in_rect_top     = '0;
    in_rect_width   = '0;
    in_rect_height  = '0;
    rep_count       = 0;
    fail_count      = 0;
    idle_pct        = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    test_first_group();
    test_overlap_rules();
    test_tie_break();
    test_coordinate_extremes();
    test_table_full();
    wait_drained();

    test_random_traffic(200, 0);
    test_random_traffic(200, 60);
    test_random_traffic(200, 20);

    if (awaited_results.size() != 0) begin
      fail_count++;
      $display("results never arrived: %0d", awaited_results.size());
    end
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
design/oga_pkg.sv
design/oga_store.sv
design/oga_area.sv
design/oga_ctrl.sv
design/overlap_group_assigner.sv
tb/overlap_group_assigner_test.sv
